>>> rtl/ccr_pkg.sv
`timescale 1ns / 1ps

package ccr_pkg;

   localparam int LEVELS_BITS   = 3;
   localparam int QUARTER_SHIFT = 2;
   localparam int QUARTER_BIAS  = 2;

   typedef struct packed {
      logic enable;   // this stage refines; otherwise it forwards beats unchanged
      logic flush;    // forget the held point
   } cell_ctrl_type;

endpackage

>>> rtl/ccr_req_if.sv
`timescale 1ns / 1ps

interface ccr_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         is_final;

   modport source (output valid, output point_x, output point_y, output is_final,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input is_final,
                   output ready);
endinterface

>>> rtl/ccr_rsp_if.sv
`timescale 1ns / 1ps

interface ccr_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic                         out_final;

   modport source (output valid, output out_x, output out_y, output out_final,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input out_final,
                   output ready);
endinterface

>>> rtl/ccr_cell.sv
`timescale 1ns / 1ps

module ccr_cell #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ccr_pkg::cell_ctrl_type       ctrl,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic                         in_fin,
   input  logic                         in_kill,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic                         out_fin,
   output logic                         out_kill
);

   logic                         prior_valid_ff, prior_valid_in;
   logic signed [COORD_BITS-1:0] prior_x_ff, prior_x_in;
   logic signed [COORD_BITS-1:0] prior_y_ff, prior_y_in;

   logic                         o_valid_ff, o_valid_in;
   logic signed [COORD_BITS-1:0] o_x_ff, o_x_in;
   logic signed [COORD_BITS-1:0] o_y_ff, o_y_in;
   logic                         o_fin_ff, o_fin_in;
   logic                         o_kill_ff, o_kill_in;

   logic                         s_valid_ff, s_valid_in;
   logic signed [COORD_BITS-1:0] s_x_ff, s_x_in;
   logic signed [COORD_BITS-1:0] s_y_ff, s_y_in;
   logic                         s_fin_ff, s_fin_in;

   logic                         o_free;
   logic                         take;
   logic signed [COORD_BITS:0]   px_ext, py_ext, ix_ext, iy_ext;
   logic signed [COORD_BITS+1:0] dx_sum, dy_sum;
   logic signed [COORD_BITS:0]   qx, qy;
   logic signed [COORD_BITS:0]   first_x, first_y, second_x, second_y;

   // quarter of the step, rounded as floor((d + 2) / 4); d + 2 needs two extra bits
   always_comb begin
      px_ext   = {prior_x_ff[COORD_BITS-1], prior_x_ff};
      py_ext   = {prior_y_ff[COORD_BITS-1], prior_y_ff};
      ix_ext   = {in_x[COORD_BITS-1], in_x};
      iy_ext   = {in_y[COORD_BITS-1], in_y};
      dx_sum   = {ix_ext[COORD_BITS], ix_ext} - {px_ext[COORD_BITS], px_ext}
                 + (COORD_BITS+2)'(ccr_pkg::QUARTER_BIAS);
      dy_sum   = {iy_ext[COORD_BITS], iy_ext} - {py_ext[COORD_BITS], py_ext}
                 + (COORD_BITS+2)'(ccr_pkg::QUARTER_BIAS);
      qx       = (COORD_BITS+1)'(dx_sum >>> ccr_pkg::QUARTER_SHIFT);
      qy       = (COORD_BITS+1)'(dy_sum >>> ccr_pkg::QUARTER_SHIFT);
      first_x  = px_ext + qx;
      first_y  = py_ext + qy;
      second_x = ix_ext - qx;
      second_y = iy_ext - qy;
   end

   assign o_free   = !o_valid_ff || out_ready;
   assign in_ready = o_free && !s_valid_ff;
   assign take     = in_valid && in_ready;

   always_comb begin
      prior_valid_in = prior_valid_ff;
      prior_x_in     = prior_x_ff;
      prior_y_in     = prior_y_ff;
      o_valid_in     = o_valid_ff;
      o_x_in         = o_x_ff;
      o_y_in         = o_y_ff;
      o_fin_in       = o_fin_ff;
      o_kill_in      = o_kill_ff;
      s_valid_in     = s_valid_ff;
      s_x_in         = s_x_ff;
      s_y_in         = s_y_ff;
      s_fin_in       = s_fin_ff;

      if (o_free) begin
         o_valid_in = 1'b0;
      end

      // advance the second cut point into the output slot
      if (s_valid_ff && o_free) begin
         o_valid_in = 1'b1;
         o_x_in     = s_x_ff;
         o_y_in     = s_y_ff;
         o_fin_in   = s_fin_ff;
         o_kill_in  = 1'b0;
         s_valid_in = 1'b0;
      end

      if (take) begin
         if (!ctrl.enable) begin
            o_valid_in = 1'b1;
            o_x_in     = in_x;
            o_y_in     = in_y;
            o_fin_in   = in_fin;
            o_kill_in  = in_kill;
         end else if (in_kill) begin
            // an upstream stage dropped the final point: clear and pass the kill on
            prior_valid_in = 1'b0;
            o_valid_in     = 1'b1;
            o_fin_in       = 1'b0;
            o_kill_in      = 1'b1;
         end else begin
            prior_x_in     = in_x;
            prior_y_in     = in_y;
            prior_valid_in = !in_fin;
            if (prior_valid_ff) begin
               o_valid_in = 1'b1;
               o_x_in     = first_x[COORD_BITS-1:0];
               o_y_in     = first_y[COORD_BITS-1:0];
               o_fin_in   = 1'b0;
               o_kill_in  = 1'b0;
               s_valid_in = 1'b1;
               s_x_in     = second_x[COORD_BITS-1:0];
               s_y_in     = second_y[COORD_BITS-1:0];
               s_fin_in   = in_fin;
            end else if (in_fin) begin
               // lone final point: no output, clear the stages downstream
               o_valid_in = 1'b1;
               o_fin_in   = 1'b0;
               o_kill_in  = 1'b1;
            end
         end
      end

      if (ctrl.flush) begin
         prior_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_valid_ff <= 1'b0;
         o_valid_ff     <= 1'b0;
         s_valid_ff     <= 1'b0;
      end else begin
         prior_valid_ff <= prior_valid_in;
         o_valid_ff     <= o_valid_in;
         s_valid_ff     <= s_valid_in;
      end
      prior_x_ff <= prior_x_in;
      prior_y_ff <= prior_y_in;
      o_x_ff     <= o_x_in;
      o_y_ff     <= o_y_in;
      o_fin_ff   <= o_fin_in;
      o_kill_ff  <= o_kill_in;
      s_x_ff     <= s_x_in;
      s_y_ff     <= s_y_in;
      s_fin_ff   <= s_fin_in;
   end

   assign out_valid = o_valid_ff;
   assign out_x     = o_x_ff;
   assign out_y     = o_y_ff;
   assign out_fin   = o_fin_ff;
   assign out_kill  = o_kill_ff;

endmodule

>>> rtl/corner_cutting_curve_refiner.sv
`timescale 1ns / 1ps

// Chaikin corner-cutting refiner for an open polygon streamed one control point
// per beat, the last point flagged. A row of MAX_LEVELS identical stages does
// the work; the first csr_wdata stages (capped at MAX_LEVELS) each cut corners
// and the rest forward beats unchanged, so zero levels passes points through.
// A refining stage turns each point after the first into two results and
// delivers one beat per cycle unless its output stalls, so with L levels an
// input point gives up to 2^L results at one result per cycle when the output
// does not stall; the next point is taken once the first stage has emitted the
// two cut points of the previous one. A point reaches its first result through
// the output register of each of the MAX_LEVELS stages. With one or more levels
// a one-point polygon gives no result. Writing csr_wdata starts a new polygon;
// the user must do so only while the block is idle; the block does not check.
module corner_cutting_curve_refiner #(
   parameter int MAX_LEVELS = 6,
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ccr_req_if.sink                             req_chan,
   ccr_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [ccr_pkg::LEVELS_BITS-1:0]     csr_wdata
);

   logic [ccr_pkg::LEVELS_BITS-1:0] levels_ff, levels_in;

   logic                         link_valid [MAX_LEVELS+1];
   logic                         link_ready [MAX_LEVELS+1];
   logic signed [COORD_BITS-1:0] link_x     [MAX_LEVELS+1];
   logic signed [COORD_BITS-1:0] link_y     [MAX_LEVELS+1];
   logic                         link_fin   [MAX_LEVELS+1];
   logic                         link_kill  [MAX_LEVELS+1];

   assign levels_in = csr_we ? csr_wdata : levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '0;
      end else begin
         levels_ff <= levels_in;
      end
   end

   assign link_valid[0]  = req_chan.valid;
   assign req_chan.ready = link_ready[0];
   assign link_x[0]      = req_chan.point_x;
   assign link_y[0]      = req_chan.point_y;
   assign link_fin[0]    = req_chan.is_final;
   assign link_kill[0]   = 1'b0;

   for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
      ccr_pkg::cell_ctrl_type ctrl;

      assign ctrl.enable = levels_ff > ccr_pkg::LEVELS_BITS'(i);
      assign ctrl.flush  = csr_we;

      ccr_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_x      (link_x[i]),
         .in_y      (link_y[i]),
         .in_fin    (link_fin[i]),
         .in_kill   (link_kill[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_x     (link_x[i+1]),
         .out_y     (link_y[i+1]),
         .out_fin   (link_fin[i+1]),
         .out_kill  (link_kill[i+1])
      );
   end

   // drop kill beats at the end of the row
   assign rsp_chan.valid          = link_valid[MAX_LEVELS] && !link_kill[MAX_LEVELS];
   assign link_ready[MAX_LEVELS]  = rsp_chan.ready || link_kill[MAX_LEVELS];
   assign rsp_chan.out_x          = link_x[MAX_LEVELS];
   assign rsp_chan.out_y          = link_y[MAX_LEVELS];
   assign rsp_chan.out_final      = link_fin[MAX_LEVELS];

endmodule

>>> dv/corner_cutting_curve_refiner_checker.sv
`timescale 1ns / 1ps

module corner_cutting_curve_refiner_checker #(
   parameter int MAX_LEVELS = 6,
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ccr_req_if         req_mon,
   ccr_rsp_if         rsp_mon,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata,
   output int         error_count,
   output int         outstanding
);

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         fin;
   } point_type;

   logic [2:0]                   levels_q;
   logic signed [COORD_BITS-1:0] held_x  [MAX_LEVELS];
   logic signed [COORD_BITS-1:0] held_y  [MAX_LEVELS];
   logic                         held_ok [MAX_LEVELS];
   point_type                    refined_q [$];
   point_type                    seen;
   point_type                    want;

   function automatic void forget_held();
      for (int lv = 0; lv < MAX_LEVELS; lv++) held_ok[lv] = 1'b0;
   endfunction

   // Run one control point through the active passes and queue what comes out.
   function automatic void cut_corners(input point_type first);
      point_type cur [$];
      point_type nxt [$];
      point_type p, a, b;
      int        passes, dx, dy, qx, qy;
      bit        lost_final;
      passes     = (levels_q > MAX_LEVELS) ? MAX_LEVELS : int'(levels_q);
      lost_final = 1'b0;
      cur.insert(cur.size(), first);
      for (int lv = 0; lv < passes; lv++) begin
         nxt.delete();
         foreach (cur[i]) begin
            p = cur[i];
            if (held_ok[lv]) begin
               dx = int'(p.x) - int'(held_x[lv]);
               dy = int'(p.y) - int'(held_y[lv]);
               // floor((d + 2) / 4)
               qx = (dx + 2) >>> 2;
               qy = (dy + 2) >>> 2;
               a.x   = COORD_BITS'(int'(held_x[lv]) + qx);
               a.y   = COORD_BITS'(int'(held_y[lv]) + qy);
               a.fin = 1'b0;
               b.x   = COORD_BITS'(int'(p.x) - qx);
               b.y   = COORD_BITS'(int'(p.y) - qy);
               b.fin = p.fin;
               nxt.insert(nxt.size(), a);
               nxt.insert(nxt.size(), b);
            end else if (p.fin) begin
               lost_final = 1'b1;
            end
            held_x[lv]  = p.x;
            held_y[lv]  = p.y;
            held_ok[lv] = !p.fin;
         end
         cur = nxt;
      end
      if (lost_final) forget_held();
      foreach (cur[i]) refined_q.insert(refined_q.size(), cur[i]);
   endfunction

   initial begin
      error_count = 0;
      outstanding = 0;
      levels_q    = '0;
      forget_held();
   end

   always @(posedge clock) begin
      if (reset) begin
         levels_q = '0;
         forget_held();
         for (int lv = 0; lv < MAX_LEVELS; lv++) begin
            held_x[lv] = '0;
            held_y[lv] = '0;
         end
         refined_q.delete();
      end else begin
         if (csr_we) begin
            levels_q = csr_wdata;
            forget_held();
         end
         if (req_mon.valid && req_mon.ready) begin
            seen.x   = req_mon.point_x;
            seen.y   = req_mon.point_y;
            seen.fin = req_mon.is_final;
            cut_corners(seen);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.x   = rsp_mon.out_x;
            seen.y   = rsp_mon.out_y;
            seen.fin = rsp_mon.out_final;
            if (refined_q.size() == 0) begin
               $display("%0t: unexpected refined point x=%0d y=%0d final=%0b",
                        $time, seen.x, seen.y, seen.fin);
               error_count++;
            end else begin
               want = refined_q.pop_front();
               if (seen.x !== want.x || seen.y !== want.y || seen.fin !== want.fin) begin
                  $display({"%0t: refined point mismatch: expected x=%0d y=%0d final=%0b,",
                            " got x=%0d y=%0d final=%0b"},
                           $time, want.x, want.y, want.fin, seen.x, seen.y, seen.fin);
                  error_count++;
               end
            end
         end
      end
      outstanding = refined_q.size();
   end

endmodule

>>> dv/corner_cutting_curve_refiner_test.sv
`timescale 1ns / 1ps

module corner_cutting_curve_refiner_test;

   localparam int MAX_LEVELS   = 6;
   localparam int COORD_BITS   = 16;
   localparam int RANDOM_ITEMS = 230;
   localparam int SETTLE       = 4 * MAX_LEVELS;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_wdata;
   logic       calm;
   int         error_count;
   int         outstanding;
   int         points_sent;
   int         cycle_count;
   int         phase;

   ccr_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   ccr_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan ();

   corner_cutting_curve_refiner #(
      .MAX_LEVELS(MAX_LEVELS),
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   corner_cutting_curve_refiner_checker #(
      .MAX_LEVELS(MAX_LEVELS),
      .COORD_BITS(COORD_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stall the result side at random outside the calm stretch
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 34);
   end

   task automatic send_point(input int x, input int y, input logic last);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 34) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.point_x  <= coord_type'(x);
      req_chan.point_y  <= coord_type'(y);
      req_chan.is_final <= last;
      do @(posedge clock); while (!req_chan.ready);
      points_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // a dropped single point leaves no result to wait for
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_levels(input logic [2:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic coord_type pick_coord(input coord_type near);
      int mode;
      mode = $urandom_range(9);
      if (mode < 4) return coord_type'($urandom);
      if (mode < 5) return $urandom_range(1) ? coord_type'(16'h7fff) : coord_type'(16'h8000);
      return near + coord_type'(int'($urandom_range(8)) - 4);
   endfunction

   task automatic send_polygon();
      int        count;
      coord_type x, y;
      logic      closes;
      count  = ($urandom_range(99) < 15) ? 1 : $urandom_range(2, 8);
      closes = $urandom_range(99) < 90;
      x      = coord_type'($urandom);
      y      = coord_type'($urandom);
      for (int k = 0; k < count; k++) begin
         x = pick_coord(x);
         y = pick_coord(y);
         send_point(int'(x), int'(y), closes && k == count - 1);
      end
   endtask

   initial begin
      int random_goal;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      calm             = 1'b0;
      cycle_count      = 0;
      points_sent      = 0;
      req_chan.valid    = 1'b0;
      req_chan.point_x  = '0;
      req_chan.point_y  = '0;
      req_chan.is_final = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through at the coordinate extremes
      set_levels(3'd0);
      send_point(-32768, 32767, 1'b0);
      send_point(32767, -32768, 1'b1);
      send_point(0, 0, 1'b1);

      // one pass across the full range, then a lone final point
      set_levels(3'd1);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(-32768, 32767, 1'b1);
      send_point(5, -5, 1'b1);
      send_point(1, 2, 1'b0);

      // writing levels drops the held point, so this final stands alone
      set_levels(3'd2);
      send_point(3, 4, 1'b1);
      send_point(-1, -1, 1'b0);
      send_point(2, -3, 1'b1);

      // above the maximum acts as the maximum
      set_levels(3'd7);
      send_point(100, -100, 1'b0);
      send_point(-100, 100, 1'b1);

      random_goal = points_sent + RANDOM_ITEMS;
      phase = 0;
      while (points_sent < random_goal) begin
         case (phase)
            0:       set_levels(3'd6);
            1:       set_levels(3'd2);
            2:       set_levels(3'd7);
            3:       set_levels(3'd0);
            4:       set_levels(3'd1);
            5:       set_levels(3'd3);
            6:       set_levels(3'd5);
            7:       set_levels(3'd4);
            default: set_levels(3'($urandom_range(7)));
         endcase
         calm = (phase == 4 || phase == 5);
         repeat ($urandom_range(3, 6)) send_polygon();
         phase++;
      end
      calm = 1'b0;

      drain();
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/ccr_pkg.sv
rtl/ccr_req_if.sv
rtl/ccr_rsp_if.sv
rtl/ccr_cell.sv
rtl/corner_cutting_curve_refiner.sv
dv/corner_cutting_curve_refiner_checker.sv
dv/corner_cutting_curve_refiner_test.sv
